// ----- hdl/multiwidth_signed_unsigned_divider_defines.svh -----
// Assertion macros shared by the divider checker.
// No dependencies.
`ifndef MULTIWIDTH_SIGNED_UNSIGNED_DIVIDER_DEFINES_SVH
`define MULTIWIDTH_SIGNED_UNSIGNED_DIVIDER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MSUD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MSUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/msud_pkg.sv -----
// Types, constants and helpers for the multi-width divider.
// No dependencies.
package msud_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumW  = 64;
  localparam int unsigned DefStages = 8;

  typedef enum logic [3:0] {
    OP_U8DIV = 4'd0, OP_U8MOD = 4'd1, OP_S8DIV = 4'd2, OP_S8MOD = 4'd3,
    OP_U16DIV = 4'd4, OP_U16MOD = 4'd5, OP_S16DIV = 4'd6, OP_S16MOD = 4'd7,
    OP_U16DIV3 = 4'd8, OP_U32DIV = 4'd9, OP_U32MOD = 4'd10,
    OP_S32DIV = 4'd11, OP_S32MOD = 4'd12
  } op_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] dividend;
    logic [31:0] dividend_high;
    logic [31:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        div_by_zero;
  } out_item_t;

  // Per-item control carried alongside the datapath through the stages.
  typedef struct packed {
    logic        bypass;   // result fixed at entry (zero operand, unknown op)
    logic [31:0] byp_q;
    logic [31:0] byp_r;
    logic        byp_f;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] mask;
  } ctl_t;

  // One iteration of the datapath: a partial remainder and quotient bits.
  typedef struct packed {
    logic [32:0] rem;
    logic [63:0] num;    // shifts left, quotient bits enter from the bottom
    logic [31:0] dvs;
  } dp_t;
endpackage

// ----- hdl/msud_stage.sv -----
// One pipeline stage of the restoring divider: a group of quotient bits.
// Depends on msud_pkg.
module msud_stage #(
  parameter int unsigned Steps = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  msud_pkg::dp_t   in_dp,
  input  msud_pkg::ctl_t  in_ctl,
  output logic            out_v,
  output msud_pkg::dp_t   out_dp,
  output msud_pkg::ctl_t  out_ctl
);
  import msud_pkg::*;

  logic   v_r;
  dp_t    dp_r, dp_nxt;
  ctl_t   ctl_r;

  always_comb begin
    logic [33:0] trial;
    logic [32:0] rem;
    logic [63:0] num;
    rem = in_dp.rem;
    num = in_dp.num;
    for (int i = 0; i < Steps; i++) begin
      trial = {rem, num[63]} - {2'b00, in_dp.dvs};
      if (!trial[33]) begin
        rem = trial[32:0];
        num = {num[62:0], 1'b1};
      end else begin
        rem = {rem[31:0], num[63]};
        num = {num[62:0], 1'b0};
      end
    end
    dp_nxt.rem = rem;
    dp_nxt.num = num;
    dp_nxt.dvs = in_dp.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r  <= dp_nxt;
      ctl_r <= in_ctl;
    end
  end

  assign out_v   = v_r;
  assign out_dp  = dp_r;
  assign out_ctl = ctl_r;
endmodule

// ----- hdl/multiwidth_signed_unsigned_divider.sv -----
// Top level of the pipelined multi-width divider.
// Depends on msud_pkg and msud_stage.
//
// A fully pipelined restoring divider: one transaction enters per cycle while
// the output is not stalled. Each result passes an input register, Stages
// stages of 64/Stages quotient bits each (64 quotient bits in all) and an
// output register. Narrow operations are zero-extended into the 64-bit
// numerator, so every width runs through the same stages. A stall freezes
// the whole pipe.
module multiwidth_signed_unsigned_divider #(
  parameter int unsigned Stages = msud_pkg::DefStages
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msud_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msud_pkg::out_item_t  out_data
);
  import msud_pkg::*;

  localparam int unsigned Steps = NumW / Stages;

  logic       en;
  logic       out_v_r;
  out_item_t  out_r, out_nxt;

  // Entry decode and register.
  logic  v0_r;
  dp_t   dp0_r, dp0_nxt;
  ctl_t  ctl0_r, ctl0_nxt;

  assign en = !out_v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [31:0] m, s, a, b, ma, mb;
    logic        na, nb, sgn, known;
    m = 32'hffffffff; sgn = 1'b0; known = 1'b1;
    b = in_data.divisor;
    case (in_data.op)
      OP_U8DIV, OP_U8MOD: m = 32'h000000ff;
      OP_S8DIV, OP_S8MOD: begin m = 32'h000000ff; sgn = 1'b1; end
      OP_U16DIV, OP_U16MOD: m = 32'h0000ffff;
      OP_S16DIV, OP_S16MOD: begin m = 32'h0000ffff; sgn = 1'b1; end
      OP_U16DIV3: begin m = 32'h0000ffff; b = 32'd3; end
      OP_U32DIV, OP_U32MOD: m = 32'hffffffff;
      OP_S32DIV, OP_S32MOD: begin m = 32'hffffffff; sgn = 1'b1; end
      default: known = 1'b0;
    endcase
    s  = (m >> 1) + 32'd1;
    a  = in_data.dividend & m;
    b  = b & m;
    na = sgn && ((a & s) != 32'd0);
    nb = sgn && ((b & s) != 32'd0);
    ma = na ? ((32'd0 - a) & m) : a;
    mb = nb ? ((32'd0 - b) & m) : b;
    ctl0_nxt.mask  = m;
    ctl0_nxt.neg_q = na != nb;
    ctl0_nxt.neg_r = na;
    ctl0_nxt.bypass = 1'b1;
    ctl0_nxt.byp_q = 32'd0;
    ctl0_nxt.byp_r = 32'd0;
    ctl0_nxt.byp_f = 1'b0;
    dp0_nxt.rem = 33'd0;
    dp0_nxt.dvs = mb;
    dp0_nxt.num = {32'd0, ma};
    if (!known) begin
      ctl0_nxt.bypass = 1'b1;
    end else if (in_data.op == OP_U32DIV) begin
      // Long divide: numerator is the full 64-bit word.
      dp0_nxt.num = {in_data.dividend_high, in_data.dividend};
      dp0_nxt.dvs = in_data.divisor;
      ctl0_nxt.neg_q = 1'b0;
      ctl0_nxt.neg_r = 1'b0;
      if (in_data.dividend == 32'd0) begin
        ctl0_nxt.byp_r = in_data.dividend_high;
      end else if (in_data.divisor == 32'd0) begin
        ctl0_nxt.byp_q = 32'hffffffff;
        ctl0_nxt.byp_r = in_data.dividend;
        ctl0_nxt.byp_f = 1'b1;
      end else begin
        ctl0_nxt.bypass = 1'b0;
      end
    end else if (a == 32'd0) begin
      ctl0_nxt.bypass = 1'b1;
    end else if (b == 32'd0) begin
      ctl0_nxt.byp_q = m;
      ctl0_nxt.byp_r = a;
      ctl0_nxt.byp_f = 1'b1;
    end else begin
      ctl0_nxt.bypass = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp0_r  <= dp0_nxt;
      ctl0_r <= ctl0_nxt;
    end
  end

  logic  v   [Stages+1];
  dp_t   dp  [Stages+1];
  ctl_t  ctl [Stages+1];

  assign v[0]   = v0_r;
  assign dp[0]  = dp0_r;
  assign ctl[0] = ctl0_r;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    msud_stage #(.Steps(Steps)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_v(v[g]), .in_dp(dp[g]), .in_ctl(ctl[g]),
      .out_v(v[g+1]), .out_dp(dp[g+1]), .out_ctl(ctl[g+1])
    );
  end

  // Sign fix-up and output register.
  always_comb begin
    logic [31:0] q, r;
    ctl_t c;
    c = ctl[Stages];
    q = dp[Stages].num[31:0] & c.mask;
    r = dp[Stages].rem[31:0] & c.mask;
    if (c.neg_q) q = (32'd0 - q) & c.mask;
    if (c.neg_r) r = (32'd0 - r) & c.mask;
    if (c.bypass) begin
      out_nxt.quotient    = c.byp_q;
      out_nxt.remainder   = c.byp_r;
      out_nxt.div_by_zero = c.byp_f;
    end else begin
      out_nxt.quotient    = q;
      out_nxt.remainder   = r;
      out_nxt.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v[Stages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;
endmodule

// ----- hdl/msud_checker.sv -----
// Port-level checker for the multi-width divider, bound to the top level.
// Depends on msud_pkg and the defines header.
`include "multiwidth_signed_unsigned_divider_defines.svh"
module msud_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input msud_pkg::out_item_t out_data
);
  import msud_pkg::*;

  `MSUD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "stalled result changed")
  `MSUD_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready,
    "input stalled while output empty")
  `MSUD_ASSERT_IMPL(a_ready_stall, clk, rst_n, out_valid && !out_ready, !in_ready,
    "input accepted while pipe frozen")
  `MSUD_ASSERT_IMPL(a_dbz_q, clk, rst_n, out_valid && out_data.div_by_zero,
    out_data.quotient == 32'h000000ff || out_data.quotient == 32'h0000ffff
    || out_data.quotient == 32'hffffffff, "zero-divisor quotient not all ones")
endmodule

bind multiwidth_signed_unsigned_divider msud_checker u_msud_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- bench/tb_multiwidth_signed_unsigned_divider.sv -----
// Self-checking testbench for the pipelined multi-width divider.
// Depends on msud_pkg and multiwidth_signed_unsigned_divider.
module tb_multiwidth_signed_unsigned_divider;
  timeunit 1ns;
  timeprecision 1ps;
  import msud_pkg::*;

  localparam int unsigned NumRandom = 1530;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PipeDrain = 40;
  localparam logic [3:0] OpBad = 4'd13;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  out_item_t quot_rem_q[$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned cycles = 0;
  int unsigned zero_div_seen = 0;
  bit stim_done = 1'b0;

  multiwidth_signed_unsigned_divider dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Divide at a given width, handling sign by magnitude.
  function automatic out_item_t divide_at(int unsigned w, bit sgn,
                                          logic [31:0] a_in, logic [31:0] b_in);
    logic [31:0] m, s, a, b, ma, mb, qq, rr;
    bit na, nb;
    out_item_t res;
    m = (w == 8) ? 32'hff : (w == 16) ? 32'hffff : 32'hffff_ffff;
    s = (m >> 1) + 32'd1;
    a = a_in & m;
    b = b_in & m;
    res = '0;
    if (a == 0) return res;
    if (b == 0) begin
      res.quotient = m;
      res.remainder = a;
      res.div_by_zero = 1'b1;
      return res;
    end
    na = sgn && ((a & s) != 0);
    nb = sgn && ((b & s) != 0);
    ma = na ? ((32'd0 - a) & m) : a;
    mb = nb ? ((32'd0 - b) & m) : b;
    qq = ma / mb;
    rr = ma % mb;
    if (na != nb) qq = (32'd0 - qq) & m;
    if (na) rr = (32'd0 - rr) & m;
    res.quotient = qq & m;
    res.remainder = rr & m;
    return res;
  endfunction

  function automatic out_item_t predict_division(in_item_t t);
    out_item_t res;
    logic [63:0] num;
    res = '0;
    case (t.op)
      OP_U8DIV, OP_U8MOD: res = divide_at(8, 0, t.dividend, t.divisor);
      OP_S8DIV, OP_S8MOD: res = divide_at(8, 1, t.dividend, t.divisor);
      OP_U16DIV, OP_U16MOD: res = divide_at(16, 0, t.dividend, t.divisor);
      OP_S16DIV, OP_S16MOD: res = divide_at(16, 1, t.dividend, t.divisor);
      OP_U16DIV3: res = divide_at(16, 0, t.dividend, 32'd3);
      OP_U32DIV: begin
        if (t.dividend == 0) begin
          res.remainder = t.dividend_high;
        end else if (t.divisor == 0) begin
          res.quotient = 32'hffff_ffff;
          res.remainder = t.dividend;
          res.div_by_zero = 1'b1;
        end else begin
          num = {t.dividend_high, t.dividend};
          res.quotient = 32'(num / {32'd0, t.divisor});
          res.remainder = 32'(num % {32'd0, t.divisor});
        end
      end
      OP_U32MOD: res = divide_at(32, 0, t.dividend, t.divisor);
      OP_S32DIV, OP_S32MOD: res = divide_at(32, 1, t.dividend, t.divisor);
      default: res = '0;
    endcase
    return res;
  endfunction

  typedef struct {
    in_item_t stim;
    bit has_exp;
    out_item_t exp;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{OP_U8DIV, 32'd200, 32'd0, 32'd7}, 0, '0},
    '{'{OP_U8MOD, 32'hff, 32'd0, 32'hff}, 1, '{32'd1, 32'd0, 1'b0}},
    '{'{OP_S8DIV, 32'h80, 32'd0, 32'hff}, 1, '{32'h80, 32'd0, 1'b0}},
    '{'{OP_S8MOD, 32'hf9, 32'd0, 32'd2}, 0, '0},
    '{'{OP_U16DIV, 32'hffff, 32'd0, 32'd1}, 1, '{32'hffff, 32'd0, 1'b0}},
    '{'{OP_U16MOD, 32'd1000, 32'd0, 32'd0}, 1, '{32'hffff, 32'd1000, 1'b1}},
    '{'{OP_S16DIV, 32'h8000, 32'd0, 32'hffff}, 1, '{32'h8000, 32'd0, 1'b0}},
    '{'{OP_S16MOD, 32'hfff9, 32'd0, 32'd3}, 0, '0},
    '{'{OP_U16DIV3, 32'hffff, 32'd0, 32'd0}, 1, '{32'h5555, 32'd0, 1'b0}},
    '{'{OP_U16DIV3, 32'd0, 32'd0, 32'd9}, 1, '{32'd0, 32'd0, 1'b0}},
    '{'{OP_U32DIV, 32'd0, 32'h1234_5678, 32'd5}, 1, '{32'd0, 32'h1234_5678, 1'b0}},
    '{'{OP_U32DIV, 32'd7, 32'hffff_ffff, 32'd0}, 1,
      '{32'hffff_ffff, 32'd7, 1'b1}},
    '{'{OP_U32DIV, 32'hffff_ffff, 32'hffff_ffff, 32'd1}, 1,
      '{32'hffff_ffff, 32'd0, 1'b0}},
    '{'{OP_U32DIV, 32'h9abc_def0, 32'h0000_0003, 32'h8765_4321}, 0, '0},
    '{'{OP_U32MOD, 32'hffff_ffff, 32'd0, 32'hffff_ffff}, 1, '{32'd1, 32'd0, 1'b0}},
    '{'{OP_S32DIV, 32'h8000_0000, 32'd0, 32'hffff_ffff}, 1,
      '{32'h8000_0000, 32'd0, 1'b0}},
    '{'{OP_S32MOD, 32'hffff_fff9, 32'd0, 32'd2}, 0, '0},
    '{'{OP_S32DIV, 32'd0, 32'd0, 32'd0}, 1, '{32'd0, 32'd0, 1'b0}},
    '{'{OP_S8DIV, 32'h7f, 32'd0, 32'd0}, 1, '{32'hff, 32'h7f, 1'b1}},
    '{'{OpBad, 32'd55, 32'd0, 32'd3}, 1, '{32'd0, 32'd0, 1'b0}},
    '{'{4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1, '{32'd0, 32'd0, 1'b0}}
  };

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(1, 4);
      2: return 32'hffff_ffff - $urandom_range(0, 2);
      3: return 32'h8000_0000 >> ($urandom_range(0, 3) * 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t t;
    t.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                        : 4'($urandom_range(0, 12));
    t.dividend = rand_operand();
    t.dividend_high = $urandom_range(0, 1) ? $urandom : rand_operand();
    t.divisor = rand_operand();
    return t;
  endfunction

  // Offers one transaction and holds it until the block accepts it.
  task automatic send_division(in_item_t t, bit has_exp, out_item_t exp);
    out_item_t pred;
    pred = predict_division(t);
    if (has_exp && pred !== exp)
      $display("%0t predictor disagrees with table: %h vs %h", $time, pred, exp);
    in_valid <= 1'b1;
    in_data <= t;
    quot_rem_q.push_back(has_exp ? exp : pred);
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic sender_gap();
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_division(dir_rows[i].stim, dir_rows[i].has_exp, dir_rows[i].exp);
      if (i % 4 == 3) sender_gap();
    end
    burst = 0;
    for (int unsigned n = 0; n < NumRandom; n++) begin
      send_division(rand_item(), 1'b0, '0);
      if (burst == 0) begin
        sender_gap();
        burst = $urandom_range(1, 40);
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: mostly random stalls, a long hold-off early on, and quiet stretches.
  initial begin
    int unsigned mode;
    @(posedge rst_n);
    repeat (30) @(posedge clk);
    out_ready <= 1'b0;
    repeat (60) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        if (mode == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, mode) == 0) ? 1'b0 : 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (quot_rem_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_data);
      end else begin
        exp = quot_rem_q.pop_front();
        if (out_data.div_by_zero) zero_div_seen++;
        if (out_data.quotient !== exp.quotient) begin
          errors++;
          $display("%0t quotient expected %h actual %h", $time, exp.quotient,
                   out_data.quotient);
        end
        if (out_data.remainder !== exp.remainder) begin
          errors++;
          $display("%0t remainder expected %h actual %h", $time, exp.remainder,
                   out_data.remainder);
        end
        if (out_data.div_by_zero !== exp.div_by_zero) begin
          errors++;
          $display("%0t div_by_zero expected %b actual %b", $time,
                   exp.div_by_zero, out_data.div_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t timeout, %0d results outstanding", $time, quot_rem_q.size());
      $display("tb_multiwidth_signed_unsigned_divider NOT OK");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (quot_rem_q.size() == 0);
    repeat (PipeDrain) @(posedge clk);
    $display("Ran %0d divisions over all widths and signs, %0d results checked,",
             sent, received);
    $display("%0d of them divide-by-zero, with random stalls on both sides.",
             zero_div_seen);
    if (errors == 0 && quot_rem_q.size() == 0) begin
      $display("tb_multiwidth_signed_unsigned_divider OK");
    end else begin
      $display("tb_multiwidth_signed_unsigned_divider NOT OK");
    end
    $finish;
  end
endmodule
